// ===== sv/shortest_queue_dispatcher_core_defines.svh =====
// ----------------------------------------------------------------------------
// Shortest queue dispatcher assertion macros
// Concurrent assertion wrappers that drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_QUEUE_DISPATCHER_CORE_DEFINES_SVH
`define SHORTEST_QUEUE_DISPATCHER_CORE_DEFINES_SVH

`ifndef SYNTH
`define SQD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqd assertion failed");
`define SQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqd assertion failed");
`else
`define SQD_ASSERT_IMPL(lbl, ante, cons)
`define SQD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/sqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest queue dispatcher package
// Shared codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package sqd_pkg;

  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ARRIVE = 2'd1;
  localparam logic [1:0] FUNC_CLOSE  = 2'd2;
  localparam logic [1:0] FUNC_OPEN   = 2'd3;

  localparam logic [1:0] KIND_DEPART   = 2'd0;
  localparam logic [1:0] KIND_ENQUEUED = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;
  localparam logic [1:0] KIND_ACK      = 2'd3;

  localparam logic [1:0] MODE_CLOSED   = 2'd0;
  localparam logic [1:0] MODE_DRAINING = 2'd1;
  localparam logic [1:0] MODE_OPEN     = 2'd2;

  localparam logic [3:0] SERVERS_RESET = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TK_CHK,
    ST_TK_EVAL,
    ST_SRCH,
    ST_DISP,
    ST_CL_CHK,
    ST_CL_RD,
    ST_ACK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic clk_inc;
    logic idx_clr;
    logic idx_inc;
    logic best_clr;
    logic srch_step;
    logic rd_head;
    logic tk_keep;
    logic tk_depart;
    logic disp;
    logic cl_empty;
    logic cl_start;
    logic cl_rd;
    logic cl_step;
    logic cl_fin;
    logic op_do;
    logic ack;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       idx_end;
    logic       tk_skip;
    logic       tk_done;
    logic       emit_ok;
    logic       tgt_out;
    logic       tgt_empty;
    logic       tgt_one;
    logic       mv_last;
  } sts_t;

endpackage

// ===== sv/shortest_queue_dispatcher_core.sv =====
// ----------------------------------------------------------------------------
// Shortest queue dispatcher core
// Join-shortest-queue job dispatcher over a set of per-server job queues.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// in_      in   tvalid / tready    tuser func, tdata tag, length, target
// out_     out  tvalid / tready    tuser kind, tdata tag, time, server, tlast
// cfg_     in   APB, pready high   servers_in_use at byte address 0
//
// One request is handled at a time. A tick visits each server in use,
// reading the head job of a busy one and skipping an idle one; an arrival
// scans every server in use; a close sends each waiting job of its server
// through a new scan in turn, on the single scan unit and the one read port
// of the job memory. Reset is synchronous; the job memory is not cleared.
// A stalled output holds the sequencer only while a result is staged.
`include "shortest_queue_dispatcher_core_defines.svh"

module shortest_queue_dispatcher_core #(
  parameter int MAX_SERVERS = 8,
  parameter int QUEUE_DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // job_tag, service_length, target_server
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_tag, event_time, server_index
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sqd_pkg::*;

  logic [3:0] sui_r;
  cmd_t       cmd;
  sts_t       sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {28'd0, sui_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sui_r <= SERVERS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'b0) begin
      sui_r <= cfg_pwdata[3:0];
    end
  end

  sqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sqd_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .servers_in_use (sui_r),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast)
  );

  `SQD_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `SQD_ASSERT_IMPL(a_no_emit_when_blocked, !sts.emit_ok,
                   !(cmd.disp || cmd.ack || cmd.tk_depart || cmd.flush))
  `SQD_ASSERT_IMPL(a_single_result_source, cmd.disp || cmd.ack || cmd.tk_depart,
                   $onehot({cmd.disp, cmd.ack, cmd.tk_depart}))

endmodule

// ===== sv/sqd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Shortest queue dispatcher controller
// Sequences ticks, arrivals, closes and opens through the datapath.
// ----------------------------------------------------------------------------
module sqd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sqd_pkg::sts_t sts,
  output sqd_pkg::cmd_t cmd
);
  import sqd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.func)
          FUNC_TICK:   state_nxt = ST_TK_CHK;
          FUNC_ARRIVE: state_nxt = ST_SRCH;
          FUNC_CLOSE:  state_nxt = ST_CL_CHK;
          default:     state_nxt = ST_ACK;
        endcase
      end
      ST_TK_CHK: begin
        if (sts.idx_end) state_nxt = ST_FLUSH;
        else if (!sts.tk_skip) state_nxt = ST_TK_EVAL;
      end
      ST_TK_EVAL: begin
        if (!sts.tk_done || sts.emit_ok) state_nxt = ST_TK_CHK;
      end
      ST_SRCH: begin
        if (sts.idx_end) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (sts.emit_ok) begin
          if (sts.func == FUNC_ARRIVE || sts.mv_last) state_nxt = ST_FLUSH;
          else state_nxt = ST_CL_RD;
        end
      end
      ST_CL_CHK: begin
        if (sts.tgt_out || sts.tgt_empty || sts.tgt_one) state_nxt = ST_ACK;
        else state_nxt = ST_CL_RD;
      end
      ST_CL_RD: state_nxt = ST_SRCH;
      ST_ACK: begin
        if (sts.emit_ok) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (sts.emit_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECODE: begin
        cmd.idx_clr  = 1'b1;
        cmd.best_clr = 1'b1;
        cmd.clk_inc  = (sts.func == FUNC_TICK);
        cmd.op_do    = (sts.func == FUNC_OPEN);
      end
      ST_TK_CHK: begin
        if (!sts.idx_end) begin
          cmd.idx_inc = sts.tk_skip;
          cmd.rd_head = !sts.tk_skip;
        end
      end
      ST_TK_EVAL: begin
        cmd.tk_keep   = !sts.tk_done;
        cmd.tk_depart = sts.tk_done && sts.emit_ok;
      end
      ST_SRCH: begin
        cmd.srch_step = !sts.idx_end;
      end
      ST_DISP: begin
        if (sts.emit_ok) begin
          cmd.disp = 1'b1;
          if (sts.func != FUNC_ARRIVE) begin
            cmd.cl_step = 1'b1;
            cmd.cl_fin  = sts.mv_last;
          end
        end
      end
      ST_CL_CHK: begin
        if (!sts.tgt_out) begin
          cmd.cl_empty = sts.tgt_empty;
          cmd.cl_start = !sts.tgt_empty;
          cmd.cl_fin   = sts.tgt_one;
        end
      end
      ST_CL_RD: begin
        cmd.cl_rd    = 1'b1;
        cmd.idx_clr  = 1'b1;
        cmd.best_clr = 1'b1;
      end
      ST_ACK:   cmd.ack = sts.emit_ok;
      ST_FLUSH: cmd.flush = sts.emit_ok;
      default: ;
    endcase
  end

endmodule

// ===== sv/sqd_dp.sv =====
// ----------------------------------------------------------------------------
// Shortest queue dispatcher datapath
// Server state, job memory, shortest queue scan and the result registers.
// ----------------------------------------------------------------------------
module sqd_dp #(
  parameter int MAX_SERVERS = 8,
  parameter int QUEUE_DEPTH = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [39:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic [3:0]    servers_in_use,
  input  sqd_pkg::cmd_t cmd,
  output sqd_pkg::sts_t sts,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [55:0]   out_tdata,
  output logic [1:0]    out_tuser,
  output logic          out_tlast
);
  import sqd_pkg::*;

  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW = $clog2(MAX_SERVERS + 1);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = SW + QW;
  localparam int MEM_DEPTH = 1 << AW;

  function automatic logic [QW-1:0] nxt_slot(input logic [QW-1:0] p);
    nxt_slot = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]  func_r;
  logic [15:0] tag_r, len_r;
  logic [2:0]  tgt_r;
  logic [31:0] clk_r;

  logic [1:0]    mode_r [MAX_SERVERS];
  logic [QW-1:0] head_r [MAX_SERVERS];
  logic [QW-1:0] tail_r [MAX_SERVERS];
  logic [OW-1:0] occ_r  [MAX_SERVERS];
  logic [15:0]   el_r   [MAX_SERVERS];

  logic [CW-1:0] idx_r;
  logic [SW-1:0] best_r;
  logic          best_ok_r;
  logic [OW-1:0] best_occ_r;
  logic [QW-1:0] p_r;
  logic [OW-1:0] wait_r;

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rd_data_r;

  logic        pend_v_r;
  logic [1:0]  pend_kind_r;
  logic [15:0] pend_tag_r;
  logic [31:0] pend_time_r;
  logic [2:0]  pend_srv_r;

  logic        out_v_r;
  logic [1:0]  out_kind_r;
  logic [15:0] out_tag_r;
  logic [31:0] out_time_r;
  logic [2:0]  out_srv_r;
  logic        out_last_r;

  logic [CW-1:0] n_w;
  logic [SW-1:0] idx_s, tgt_s;
  logic [15:0]   el_inc;
  logic [31:0]   dw;
  logic          reject;
  logic          emit;
  logic [1:0]    new_kind;
  logic [15:0]   new_tag;
  logic [2:0]    new_srv;
  logic          out_free;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    if (servers_in_use == 4'd0) n_w = CW'(1);
    else if ({4'd0, servers_in_use} > 8'(MAX_SERVERS)) n_w = CW'(MAX_SERVERS);
    else n_w = CW'(servers_in_use);
  end

  assign idx_s  = idx_r[SW-1:0];
  assign tgt_s  = SW'(tgt_r);
  assign el_inc = (el_r[idx_s] == 16'hFFFF) ? 16'hFFFF : el_r[idx_s] + 16'd1;
  assign dw     = (func_r == FUNC_ARRIVE) ? {len_r, tag_r} : rd_data_r;
  assign reject = !best_ok_r || (best_occ_r >= OW'(QUEUE_DEPTH));
  assign out_free = !out_v_r || out_tready;

  assign sts.func      = func_r;
  assign sts.idx_end   = (idx_r >= n_w);
  assign sts.tk_skip   = (occ_r[idx_s] == '0) || (mode_r[idx_s] == MODE_CLOSED);
  assign sts.tk_done   = (el_inc >= rd_data_r[31:16]);
  assign sts.emit_ok   = !pend_v_r || out_free;
  assign sts.tgt_out   = ({5'd0, tgt_r} >= 8'(n_w));
  assign sts.tgt_empty = (occ_r[tgt_s] == '0);
  assign sts.tgt_one   = (occ_r[tgt_s] == OW'(1));
  assign sts.mv_last   = (wait_r == OW'(1));

  assign emit = cmd.disp || cmd.ack || cmd.tk_depart;

  always_comb begin
    new_kind = KIND_ACK;
    new_tag  = 16'd0;
    new_srv  = tgt_r;
    if (cmd.disp) begin
      new_tag  = dw[15:0];
      new_kind = reject ? KIND_REJECTED : KIND_ENQUEUED;
      new_srv  = reject ? 3'd0 : 3'(best_r);
    end else if (cmd.tk_depart) begin
      new_kind = KIND_DEPART;
      new_tag  = rd_data_r[15:0];
      new_srv  = 3'(idx_s);
    end
  end

  assign wr_addr = {best_r, tail_r[best_r]};
  assign rd_addr = cmd.cl_rd ? {tgt_s, p_r} : {idx_s, head_r[idx_s]};

  // Job memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.disp && !reject) mem[wr_addr] <= dw;
    if (cmd.rd_head || cmd.cl_rd) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_tuser;
      tag_r  <= in_tdata[15:0];
      len_r  <= in_tdata[31:16];
      tgt_r  <= in_tdata[34:32];
    end
    if (cmd.best_clr) best_occ_r <= '0;
    if (cmd.srch_step && mode_r[idx_s] == MODE_OPEN &&
        (!best_ok_r || occ_r[idx_s] < best_occ_r)) begin
      best_r     <= idx_s;
      best_occ_r <= occ_r[idx_s];
    end
    if (cmd.cl_start) begin
      wait_r <= occ_r[tgt_s] - OW'(1);
      p_r    <= nxt_slot(head_r[tgt_s]);
    end else if (cmd.cl_step) begin
      wait_r <= wait_r - OW'(1);
      p_r    <= nxt_slot(p_r);
    end
    if (emit) begin
      pend_kind_r <= new_kind;
      pend_tag_r  <= new_tag;
      pend_time_r <= clk_r;
      pend_srv_r  <= new_srv;
    end
    if ((emit || cmd.flush) && pend_v_r) begin
      out_kind_r <= pend_kind_r;
      out_tag_r  <= pend_tag_r;
      out_time_r <= pend_time_r;
      out_srv_r  <= pend_srv_r;
      out_last_r <= cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r     <= '0;
      idx_r     <= '0;
      best_ok_r <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        mode_r[i] <= MODE_OPEN;
        head_r[i] <= '0;
        tail_r[i] <= '0;
        occ_r[i]  <= '0;
        el_r[i]   <= '0;
      end
    end else begin
      if (cmd.clk_inc) clk_r <= clk_r + 32'd1;
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc || cmd.srch_step || cmd.tk_keep || cmd.tk_depart)
        idx_r <= idx_r + CW'(1);
      if (cmd.best_clr) best_ok_r <= 1'b0;
      else if (cmd.srch_step && mode_r[idx_s] == MODE_OPEN) best_ok_r <= 1'b1;

      if (cmd.tk_keep) el_r[idx_s] <= el_inc;
      if (cmd.tk_depart) begin
        head_r[idx_s] <= nxt_slot(head_r[idx_s]);
        el_r[idx_s]   <= '0;
        occ_r[idx_s]  <= occ_r[idx_s] - OW'(1);
        if (mode_r[idx_s] == MODE_DRAINING) mode_r[idx_s] <= MODE_CLOSED;
      end
      if (cmd.disp && !reject) begin
        tail_r[best_r] <= nxt_slot(tail_r[best_r]);
        occ_r[best_r]  <= best_occ_r + OW'(1);
      end
      if (cmd.cl_empty) mode_r[tgt_s] <= MODE_CLOSED;
      if (cmd.cl_start) mode_r[tgt_s] <= MODE_DRAINING;
      if (cmd.cl_fin) begin
        tail_r[tgt_s] <= nxt_slot(head_r[tgt_s]);
        occ_r[tgt_s]  <= OW'(1);
      end
      if (cmd.op_do && !sts.tgt_out) mode_r[tgt_s] <= MODE_OPEN;

      // The staged result moves to the output only once the next one or the
      // end of the request is known, so that last can be set on it.
      if ((emit || cmd.flush) && pend_v_r) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (emit) pend_v_r <= 1'b1;
      else if (cmd.flush) pend_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_srv_r, out_time_r, out_tag_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
